@@ rtl/blink_gesture_classifier_core_assert.svh @@
// Assertion macros used by the blink gesture classifier checker.
`ifndef BLINK_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define BLINK_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Check a property in the same cycle as its trigger.
`define BGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bgc check failed");

// Check a property in the cycle after its trigger.
`define BGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bgc check failed");

`endif

@@ rtl/bgc_pkg.sv @@
// Types and constants shared by the blink gesture classifier modules.
package bgc_pkg;

	localparam int THR_BITS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = FRAC_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [THR_BITS-1:0] IGNORE_RST = 16'd110;
	localparam logic [THR_BITS-1:0] SHORT_RST  = 16'd380;
	localparam logic [THR_BITS-1:0] LONG_RST   = 16'd560;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_IGNORE = 2'd0,
		REG_SHORT  = 2'd1,
		REG_LONG   = 2'd2,
		REG_SPARE  = 2'd3
	} reg_idx_t;

	// Gesture codes on the result word
	typedef enum logic [1:0] {
		G_NONE    = 2'd0,
		G_SHORT   = 2'd1,
		G_LONG    = 2'd2,
		G_DISCARD = 2'd3
	} gesture_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_WB
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic eval;
		logic div_step;
		logic out_load;
	} bgc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} bgc_sts_t;

endpackage

@@ rtl/bgc_ctrl.sv @@
// Controller state machine sequencing accept, evaluate, divide and write-back.
module bgc_ctrl
	import bgc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bgc_sts_t sts,
	output bgc_cmd_t cmd
);

	state_t state_q, state_d;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.need_div ? ST_DIV : ST_WB;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/bgc_datapath.sv @@
// Datapath: closure tracking, threshold compares, fraction divider and output word.
module bgc_datapath
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bgc_cmd_t            cmd,
	output bgc_sts_t            sts,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_data,
	input  logic                eye_shut,
	input  logic [31:0]         time_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          gesture,
	output logic                progress_valid,
	output logic [FRAC_BITS:0]  hold_fraction,
	output logic [31:0]         hold_time
);

	logic [THR_BITS-1:0]  ignore_q, short_q, long_q;
	logic                 closed_q, long_done_q;
	logic [TIME_BITS-1:0] start_q;
	logic                 shut_q, was_closed_q;
	logic [TIME_BITS-1:0] held_q;
	logic [TIME_BITS+31:0] now_ext;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] held_d;
	logic                 ge_long, ge_short, ge_ignore, le_short;
	logic [THR_BITS-1:0]  span_d, num_d;
	logic [THR_BITS-1:0]  span_q;
	logic [THR_BITS:0]    rem_q, rem_sh;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [1:0]           res_gesture_q;
	logic                 res_pvalid_q, res_long_q;
	logic                 out_valid_q;
	logic [1:0]           gesture_q;
	logic                 pvalid_q;
	logic [FRAC_BITS:0]   frac_q;
	logic [TIME_BITS+31:0] held_ext;
	logic [31:0]          hold_q;

	// Write configuration registers; spare index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q <= IGNORE_RST;
			short_q  <= SHORT_RST;
			long_q   <= LONG_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IGNORE: ignore_q <= cfg_data;
				REG_SHORT:  short_q  <= cfg_data;
				REG_LONG:   long_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Reduce timestamp to the time width and measure the hold
	assign now_ext = {{TIME_BITS{1'b0}}, time_ms};
	assign now     = now_ext[TIME_BITS-1:0];
	assign held_d  = closed_q ? (now - start_q) : '0;

	// Threshold compares on the captured hold
	assign ge_long   = held_q >= TIME_BITS'(long_q);
	assign ge_short  = held_q >= TIME_BITS'(short_q);
	assign ge_ignore = held_q >= TIME_BITS'(ignore_q);
	assign le_short  = held_q <= TIME_BITS'(short_q);
	assign span_d    = long_q - short_q;
	assign num_d     = held_q[THR_BITS-1:0] - short_q;

	// Hold closure state and capture the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q    <= 1'b0;
			long_done_q <= 1'b0;
			start_q     <= '0;
		end else if (cmd.accept) begin
			if (eye_shut && !closed_q) begin
				closed_q    <= 1'b1;
				start_q     <= now;
				long_done_q <= 1'b0;
			end else if (!eye_shut) begin
				closed_q <= 1'b0;
			end
		end else if (cmd.eval) begin
			if (shut_q && !long_done_q && ge_long) begin
				long_done_q <= 1'b1;
			end else if (!shut_q && was_closed_q) begin
				long_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			shut_q       <= eye_shut;
			was_closed_q <= closed_q;
			held_q       <= held_d;
		end
	end

	// Classify the sample
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_gesture_q <= G_NONE;
			res_pvalid_q  <= 1'b0;
			res_long_q    <= 1'b0;
			if (shut_q) begin
				if (!long_done_q && ge_long) begin
					res_gesture_q <= G_LONG;
					res_pvalid_q  <= 1'b1;
					res_long_q    <= 1'b1;
				end else if (!long_done_q && ge_short) begin
					res_pvalid_q <= 1'b1;
				end
			end else if (was_closed_q && !long_done_q) begin
				res_gesture_q <= (ge_ignore && le_short) ? G_SHORT : G_DISCARD;
			end
		end
	end

	assign sts.need_div = shut_q && !long_done_q && !ge_long && ge_short;

	// Restoring divider, one quotient bit per step
	assign rem_sh = {rem_q[THR_BITS-1:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			rem_q  <= {1'b0, num_d};
			span_q <= span_d;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (rem_sh >= {1'b0, span_q}) begin
				rem_q <= rem_sh - {1'b0, span_q};
				quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign sts.div_last = cnt_q == CNT_BITS'(DIV_STEPS - 1);

	// Output register: load the finished word, drop it when taken
	assign sts.out_free = !out_valid_q || out_ready;
	assign held_ext     = {32'd0, held_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			gesture_q <= res_gesture_q;
			pvalid_q  <= res_pvalid_q;
			hold_q    <= held_ext[31:0];
			if (res_long_q) begin
				frac_q <= FRAC_ONE;
			end else if (res_pvalid_q) begin
				frac_q <= {1'b0, quo_q};
			end else begin
				frac_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign gesture        = gesture_q;
	assign progress_valid = pvalid_q;
	assign hold_fraction  = frac_q;
	assign hold_time      = hold_q;

endmodule

@@ rtl/blink_gesture_classifier_core.sv @@
// Top level of the blink gesture classifier.
//
// Input channel (in_valid/in_ready): one word per eye sample, eye_shut and
// time_ms. Output channel (out_valid/out_ready): one result word per sample,
// gesture, progress_valid, hold_fraction and hold_time.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 ignore threshold, 1 short
// limit, 2 long threshold, cfg_data 16 bits; index 3 is ignored. Always ready;
// write only while no sample is in flight.
// Input accept leads through the evaluate state, then, when hold progress is
// computed, the 16-step restoring divider for the fraction, then write-back
// to out_valid. One sample is processed at a time, so a new sample is not
// accepted until the previous result has been loaded into the output register.
// A finished word sits in the output register while the next sample is
// accepted; if the receiver stalls, the following result waits in the
// datapath and input accepts stop until the output register frees up.
// Reset clears the closure state, restores the default thresholds and
// empties the output register.
module blink_gesture_classifier_core
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                eye_shut,
	input  logic [31:0]         time_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          gesture,
	output logic                progress_valid,
	output logic [FRAC_BITS:0]  hold_fraction,
	output logic [31:0]         hold_time
);

	bgc_cmd_t cmd;
	bgc_sts_t sts;

	assign cfg_ready = 1'b1;

	bgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bgc_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.eye_shut       (eye_shut),
		.time_ms        (time_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.gesture        (gesture),
		.progress_valid (progress_valid),
		.hold_fraction  (hold_fraction),
		.hold_time      (hold_time)
	);

endmodule

@@ rtl/bgc_checker.sv @@
// Port-level checker for the blink gesture classifier and its bind.
`include "blink_gesture_classifier_core_assert.svh"

module bgc_checker
	import bgc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         gesture,
	input logic               progress_valid,
	input logic [FRAC_BITS:0] hold_fraction,
	input logic [31:0]        hold_time
);

	// Progress only rides on no gesture or a long gesture
	`BGC_ASSERT_NOW(a_pvalid_gesture, clk, arst_n, out_valid && progress_valid, gesture == G_NONE || gesture == G_LONG)

	// No progress means a zero fraction
	`BGC_ASSERT_NOW(a_frac_zero, clk, arst_n, out_valid && !progress_valid, hold_fraction == '0)

	// Long gesture reports a full fraction
	`BGC_ASSERT_NOW(a_long_full, clk, arst_n, out_valid && gesture == G_LONG, progress_valid && hold_fraction == FRAC_ONE)

	// One sample at a time: input closes after an accept
	`BGC_ASSERT_NEXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready)

	// Stalled result word holds
	`BGC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hold_time) && $stable(gesture))

endmodule

bind blink_gesture_classifier_core bgc_checker u_bgc_checker (.*);
